/* rtl/spi_seq_pkg.sv */
// shared types, constants and command codes of the spi nor flash command sequencer
`default_nettype none

package spi_seq_pkg;

   // field widths
   localparam int MODE_BITS = 3;
   localparam int ADDR_BITS = 24;
   localparam int LEN_BITS  = 16;
   localparam int BYTE_BITS = 8;

   // page size, a power of two
   localparam int PAGE_BYTES = 256;
   localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

   // job queue depth
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // step counter of the back end
   localparam int STEP_BITS = 3;
   localparam logic [STEP_BITS-1:0] STEP_FIRST      = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_WDATA_DATA = 3'd5;

   // request modes
   localparam logic [MODE_BITS-1:0] MODE_WR_REQ  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_WR_DATA = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_RD_REQ  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_SE      = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_BE      = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_REPLY   = 3'd5;

   // flash command bytes
   localparam logic [BYTE_BITS-1:0] CMD_PROG = 8'h02;
   localparam logic [BYTE_BITS-1:0] CMD_WREN = 8'h06;
   localparam logic [BYTE_BITS-1:0] CMD_READ = 8'h03;
   localparam logic [BYTE_BITS-1:0] CMD_RDSR = 8'h05;
   localparam logic [BYTE_BITS-1:0] CMD_SE   = 8'hD8;
   localparam logic [BYTE_BITS-1:0] CMD_BE   = 8'hC7;
   localparam logic [BYTE_BITS-1:0] DUMMY    = 8'h00;
   localparam int                   WIP_POS  = 0;

   // sequencer phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WDATA,
      PH_POLL,
      PH_READ
   } spi_seq_phase_type;

   // kind of job handed from front to back
   typedef enum logic [3:0] {
      JOB_REJECT,
      JOB_WR_REQ,
      JOB_RD_REQ,
      JOB_SE,
      JOB_BE,
      JOB_WDATA,
      JOB_POLL_BUSY,
      JOB_POLL_END,
      JOB_READ_BYTE
   } spi_seq_kind_type;

   // one classified job; ends marks zero length, frame end or operation done
   typedef struct packed {
      spi_seq_kind_type       kind;
      logic [ADDR_BITS-1:0]   addr;
      logic [BYTE_BITS-1:0]   data;
      logic [STEP_BITS-1:0]   start;
      logic                   ends;
   } spi_seq_job_type;

   // one result word
   typedef struct packed {
      logic                 tx_valid;
      logic [BYTE_BITS-1:0] tx_byte;
      logic                 cs_release;
      logic                 reply_wanted;
      logic                 host_valid;
      logic [BYTE_BITS-1:0] host_data;
      logic                 done_res;
      logic                 status;
      logic                 last;
   } spi_seq_word_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } spi_seq_qstat_type;

endpackage

`default_nettype wire

/* rtl/spi_seq_if.sv */
// request and result channel interfaces of the spi nor flash command sequencer
`default_nettype none

interface spi_seq_req_if import spi_seq_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [MODE_BITS-1:0] mode;
   logic [ADDR_BITS-1:0] addr;
   logic [LEN_BITS-1:0]  length;
   logic [BYTE_BITS-1:0] data;

   modport source (output valid, output mode, output addr, output length, output data,
                   input ready);
   modport sink   (input valid, input mode, input addr, input length, input data,
                   output ready);
endinterface

interface spi_seq_rsp_if import spi_seq_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 tx_valid;
   logic [BYTE_BITS-1:0] tx_byte;
   logic                 cs_release;
   logic                 reply_wanted;
   logic                 host_valid;
   logic [BYTE_BITS-1:0] host_data;
   logic                 done_res;
   logic                 status;
   logic                 last;

   modport source (output valid, output tx_valid, output tx_byte, output cs_release,
                   output reply_wanted, output host_valid, output host_data,
                   output done_res, output status, output last, input ready);
   modport sink   (input valid, input tx_valid, input tx_byte, input cs_release,
                   input reply_wanted, input host_valid, input host_data,
                   input done_res, input status, input last, output ready);
endinterface

`default_nettype wire

/* rtl/spi_seq_front.sv */
// front end: accepts request words, tracks the phase and classifies them into jobs
`default_nettype none

module spi_seq_front import spi_seq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   spi_seq_req_if.sink            req_bus,
   input  wire spi_seq_qstat_type qstat,
   output spi_seq_job_type        job,
   output logic                   push
);

   spi_seq_phase_type    phase_ff, phase_in;
   logic [ADDR_BITS-1:0] cur_addr_ff, cur_addr_in;
   logic [LEN_BITS-1:0]  bytes_left_ff, bytes_left_in;
   logic                 page_open_ff, page_open_in;
   logic                 write_pend_ff, write_pend_in;

   logic [ADDR_BITS-1:0] next_addr;
   logic [LEN_BITS-1:0]  left_dec;
   logic                 page_end;
   logic                 wip;

   // shared arithmetic
   assign next_addr = cur_addr_ff + ADDR_BITS'(1);
   assign left_dec  = bytes_left_ff - LEN_BITS'(1);
   assign page_end  = (left_dec == '0) || (next_addr[PAGE_BITS-1:0] == '0);
   assign wip       = req_bus.data[WIP_POS];

   // handshake
   assign req_bus.ready = !qstat.full;
   assign push          = req_bus.valid && req_bus.ready;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      cur_addr_in   = cur_addr_ff;
      bytes_left_in = bytes_left_ff;
      page_open_in  = page_open_ff;
      write_pend_in = write_pend_ff;
      case (phase_ff)
         PH_IDLE: begin
            case (req_bus.mode)
               MODE_WR_REQ: begin
                  cur_addr_in   = req_bus.addr;
                  bytes_left_in = req_bus.length;
                  page_open_in  = 1'b0;
                  write_pend_in = 1'b0;
                  if (req_bus.length != '0) begin
                     phase_in = PH_WDATA;
                  end
               end
               MODE_RD_REQ: begin
                  cur_addr_in   = req_bus.addr;
                  bytes_left_in = req_bus.length;
                  if (req_bus.length != '0) begin
                     phase_in = PH_READ;
                  end
               end
               MODE_SE, MODE_BE: begin
                  phase_in      = PH_POLL;
                  write_pend_in = 1'b0;
               end
               default: ;
            endcase
         end
         PH_WDATA: begin
            if (req_bus.mode == MODE_WR_DATA) begin
               cur_addr_in   = next_addr;
               bytes_left_in = left_dec;
               if (page_end) begin
                  page_open_in  = 1'b0;
                  phase_in      = PH_POLL;
                  write_pend_in = 1'b1;
               end else begin
                  page_open_in = 1'b1;
               end
            end
         end
         PH_POLL: begin
            if (req_bus.mode == MODE_REPLY && !wip) begin
               if (write_pend_ff && bytes_left_ff != '0) begin
                  phase_in = PH_WDATA;
               end else begin
                  phase_in      = PH_IDLE;
                  write_pend_in = 1'b0;
               end
            end
         end
         PH_READ: begin
            if (req_bus.mode == MODE_REPLY) begin
               bytes_left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: ;
      endcase
   end

   // job classification
   always_comb begin
      job.kind  = JOB_REJECT;
      job.addr  = cur_addr_ff;
      job.data  = req_bus.data;
      job.start = STEP_FIRST;
      job.ends  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            case (req_bus.mode)
               MODE_WR_REQ: begin
                  job.kind = JOB_WR_REQ;
                  job.ends = (req_bus.length == '0);
               end
               MODE_RD_REQ: begin
                  job.kind = JOB_RD_REQ;
                  job.addr = req_bus.addr;
                  job.ends = (req_bus.length == '0);
               end
               MODE_SE: begin
                  job.kind = JOB_SE;
                  job.addr = req_bus.addr;
               end
               MODE_BE: begin
                  job.kind = JOB_BE;
               end
               default: ;
            endcase
         end
         PH_WDATA: begin
            if (req_bus.mode == MODE_WR_DATA) begin
               job.kind  = JOB_WDATA;
               job.start = page_open_ff ? STEP_WDATA_DATA : STEP_FIRST;
               job.ends  = page_end;
            end
         end
         PH_POLL: begin
            if (req_bus.mode == MODE_REPLY) begin
               if (wip) begin
                  job.kind = JOB_POLL_BUSY;
               end else begin
                  job.kind = JOB_POLL_END;
                  job.ends = !(write_pend_ff && bytes_left_ff != '0);
               end
            end
         end
         PH_READ: begin
            if (req_bus.mode == MODE_REPLY) begin
               job.kind = JOB_READ_BYTE;
               job.ends = (left_dec == '0);
            end
         end
         default: ;
      endcase
   end

   // state registers, updated on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         cur_addr_ff   <= '0;
         bytes_left_ff <= '0;
         page_open_ff  <= 1'b0;
         write_pend_ff <= 1'b0;
      end else if (push) begin
         phase_ff      <= phase_in;
         cur_addr_ff   <= cur_addr_in;
         bytes_left_ff <= bytes_left_in;
         page_open_ff  <= page_open_in;
         write_pend_ff <= write_pend_in;
      end
   end

   // a read or write in progress always has bytes left
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_READ) |-> (bytes_left_ff != '0))
      else $error("read phase with no bytes left");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WDATA) |-> (bytes_left_ff != '0))
      else $error("write data phase with no bytes left");

   // an open page frame only exists while write data is expected
   assert property (@(posedge clock) disable iff (reset)
      page_open_ff |-> (phase_ff == PH_WDATA))
      else $error("page frame open outside write data phase");

endmodule

`default_nettype wire

/* rtl/spi_seq_fifo.sv */
// short job queue between the front end and the back end
`default_nettype none

module spi_seq_fifo import spi_seq_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire spi_seq_job_type push_job,
   input  wire logic            pop,
   output spi_seq_job_type      pop_job,
   output spi_seq_qstat_type    qstat
);

   spi_seq_job_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   // status and read data
   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_job     = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("job queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full && !pop))
      else $error("job pushed into full queue");

   assert property (@(posedge clock) disable iff (reset)
      !(pop && qstat.empty))
      else $error("job popped from empty queue");

endmodule

`default_nettype wire

/* rtl/spi_seq_back.sv */
// back end: expands each job into result words, one word per cycle while rsp_bus is not stalled
`default_nettype none

module spi_seq_back import spi_seq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire spi_seq_qstat_type qstat,
   input  wire spi_seq_job_type   pop_job,
   output logic                   pop,
   spi_seq_rsp_if.source          rsp_bus
);

   spi_seq_job_type       job_ff, job_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   spi_seq_word_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   spi_seq_word_type      word;
   logic                  advance;
   logic                  finish;

   // word for the current job and step
   always_comb begin
      word = '0;
      case (job_ff.kind)
         JOB_WR_REQ: begin
            word.done_res = job_ff.ends;
            word.last     = 1'b1;
         end
         JOB_RD_REQ: begin
            word.tx_valid = 1'b1;
            case (step_ff)
               3'd0: word.tx_byte = CMD_READ;
               3'd1: word.tx_byte = job_ff.addr[23:16];
               3'd2: word.tx_byte = job_ff.addr[15:8];
               3'd3: begin
                  word.tx_byte    = job_ff.addr[7:0];
                  word.cs_release = job_ff.ends;
                  word.done_res   = job_ff.ends;
                  word.last       = job_ff.ends;
               end
               default: begin
                  word.tx_byte      = DUMMY;
                  word.reply_wanted = 1'b1;
                  word.last         = 1'b1;
               end
            endcase
         end
         JOB_SE: begin
            word.tx_valid = 1'b1;
            case (step_ff)
               3'd0: begin
                  word.tx_byte    = CMD_WREN;
                  word.cs_release = 1'b1;
               end
               3'd1: word.tx_byte = CMD_SE;
               3'd2: word.tx_byte = job_ff.addr[23:16];
               3'd3: word.tx_byte = job_ff.addr[15:8];
               3'd4: begin
                  word.tx_byte    = job_ff.addr[7:0];
                  word.cs_release = 1'b1;
               end
               3'd5: word.tx_byte = CMD_RDSR;
               default: begin
                  word.tx_byte      = DUMMY;
                  word.reply_wanted = 1'b1;
                  word.last         = 1'b1;
               end
            endcase
         end
         JOB_BE: begin
            word.tx_valid = 1'b1;
            case (step_ff)
               3'd0: begin
                  word.tx_byte    = CMD_WREN;
                  word.cs_release = 1'b1;
               end
               3'd1: begin
                  word.tx_byte    = CMD_BE;
                  word.cs_release = 1'b1;
               end
               3'd2: word.tx_byte = CMD_RDSR;
               default: begin
                  word.tx_byte      = DUMMY;
                  word.reply_wanted = 1'b1;
                  word.last         = 1'b1;
               end
            endcase
         end
         JOB_WDATA: begin
            word.tx_valid = 1'b1;
            case (step_ff)
               3'd0: begin
                  word.tx_byte    = CMD_WREN;
                  word.cs_release = 1'b1;
               end
               3'd1: word.tx_byte = CMD_PROG;
               3'd2: word.tx_byte = job_ff.addr[23:16];
               3'd3: word.tx_byte = job_ff.addr[15:8];
               3'd4: word.tx_byte = job_ff.addr[7:0];
               3'd5: begin
                  word.tx_byte    = job_ff.data;
                  word.cs_release = job_ff.ends;
                  word.last       = !job_ff.ends;
               end
               3'd6: word.tx_byte = CMD_RDSR;
               default: begin
                  word.tx_byte      = DUMMY;
                  word.reply_wanted = 1'b1;
                  word.last         = 1'b1;
               end
            endcase
         end
         JOB_POLL_BUSY: begin
            word.tx_valid     = 1'b1;
            word.tx_byte      = DUMMY;
            word.reply_wanted = 1'b1;
            word.last         = 1'b1;
         end
         JOB_POLL_END: begin
            word.cs_release = 1'b1;
            word.done_res   = job_ff.ends;
            word.last       = 1'b1;
         end
         JOB_READ_BYTE: begin
            word.host_valid = 1'b1;
            word.host_data  = job_ff.data;
            word.last       = 1'b1;
            if (job_ff.ends) begin
               word.cs_release = 1'b1;
               word.done_res   = 1'b1;
            end else begin
               word.tx_valid     = 1'b1;
               word.tx_byte      = DUMMY;
               word.reply_wanted = 1'b1;
            end
         end
         default: begin
            word.status = 1'b1;
            word.last   = 1'b1;
         end
      endcase
   end

   // sequencing: step through the job, take the next one on the last word
   assign advance = cur_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign finish  = advance && word.last;
   assign pop     = !qstat.empty && (!cur_valid_ff || finish);

   always_comb begin
      job_in       = job_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_in       = word;
         rsp_valid_in = 1'b1;
         step_in      = step_ff + STEP_BITS'(1);
      end
      if (finish) begin
         cur_valid_in = 1'b0;
      end
      if (pop) begin
         job_in       = pop_job;
         step_in      = pop_job.start;
         cur_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   // result channel
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.tx_valid     = rsp_ff.tx_valid;
   assign rsp_bus.tx_byte      = rsp_ff.tx_byte;
   assign rsp_bus.cs_release   = rsp_ff.cs_release;
   assign rsp_bus.reply_wanted = rsp_ff.reply_wanted;
   assign rsp_bus.host_valid   = rsp_ff.host_valid;
   assign rsp_bus.host_data    = rsp_ff.host_data;
   assign rsp_bus.done_res     = rsp_ff.done_res;
   assign rsp_bus.status       = rsp_ff.status;
   assign rsp_bus.last         = rsp_ff.last;

   // a finished job with nothing queued leaves the back end empty
   assert property (@(posedge clock) disable iff (reset)
      (finish && qstat.empty) |=> !cur_valid_ff)
      else $error("back end kept a finished job");

   // a stalled result word blocks the step counter
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready && cur_valid_ff) |=> $stable(step_ff))
      else $error("step moved while result stalled");

   // a write data job starts at the first step, or at the data step when it needs no frame header
   assert property (@(posedge clock) disable iff (reset)
      (pop && pop_job.kind == JOB_WDATA) |-> (pop_job.start == STEP_FIRST
         || pop_job.start == STEP_WDATA_DATA))
      else $error("write data job with bad start step");

endmodule

`default_nettype wire

/* rtl/spi_nor_flash_command_sequencer.sv */
// top level of the spi nor flash command sequencer
//
//   channel   dir   handshake      contents
//   req_bus   in    valid/ready    mode, addr, length, data
//   rsp_bus   out   valid/ready    tx and chip-select mark, host byte, done, status, last
//
// each request word yields one to eight result words, one word per cycle from the back end
// the front end takes a new word every cycle while the four-entry job queue has room
// the job queue lets the front keep accepting while a result waits
// synchronous active-high reset returns the phase to idle and empties the queue
// a stall on rsp_bus holds the back end; the front stalls only once the queue is full
`default_nettype none

module spi_nor_flash_command_sequencer import spi_seq_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   spi_seq_req_if.sink req_bus,
   spi_seq_rsp_if.source rsp_bus
);

   spi_seq_job_type   push_job;
   spi_seq_job_type   pop_job;
   spi_seq_qstat_type qstat;
   logic              push;
   logic              pop;

   // classification
   spi_seq_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .qstat   (qstat),
      .job     (push_job),
      .push    (push)
   );

   // job queue
   spi_seq_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .qstat    (qstat)
   );

   // word expansion
   spi_seq_back u_back (
      .clock   (clock),
      .reset   (reset),
      .qstat   (qstat),
      .pop_job (pop_job),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench of the spi nor flash command sequencer
module tb_top;
   import spi_seq_pkg::*;

   // reserved mode codes, always rejected
   localparam logic [MODE_BITS-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_RSVD7 = 3'd7;
   localparam logic [MODE_BITS-1:0] ALL_MODES [8] = '{MODE_WR_REQ, MODE_WR_DATA, MODE_RD_REQ,
      MODE_SE, MODE_BE, MODE_REPLY, MODE_RSVD6, MODE_RSVD7};

   localparam int RANDOM_ITEMS = 290;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 40;
   localparam int SHOWN_ERRORS = 10;

   // single-word results that can be read off directly
   localparam spi_seq_word_type W_REJECT = '{status: 1'b1, last: 1'b1, default: '0};
   localparam spi_seq_word_type W_DONE   = '{done_res: 1'b1, last: 1'b1, default: '0};
   localparam spi_seq_word_type W_OPEN   = '{last: 1'b1, default: '0};
   localparam spi_seq_word_type W_POLLED = '{cs_release: 1'b1, done_res: 1'b1, last: 1'b1,
                                             default: '0};
   localparam spi_seq_word_type W_NONE   = '0;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [ADDR_BITS-1:0] addr;
      logic [LEN_BITS-1:0]  length;
      logic [BYTE_BITS-1:0] data;
      logic                 typed;
      spi_seq_word_type     want;
   } probe_row_type;

   // directed stimulus, walked in order from reset
   localparam probe_row_type PROBE_ROWS [24] = '{
      '{MODE_WR_DATA, 24'h000000, 16'h0000, 8'h00, 1'b1, W_REJECT},  // data byte while idle
      '{MODE_REPLY,   24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1, W_REJECT},  // reply while idle
      '{MODE_RSVD6,   24'h000000, 16'h0000, 8'h00, 1'b1, W_REJECT},
      '{MODE_RSVD7,   24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1, W_REJECT},
      '{MODE_WR_REQ,  24'hFFFFFF, 16'h0000, 8'h00, 1'b1, W_DONE},    // zero-length write
      '{MODE_RD_REQ,  24'hFFFFFF, 16'h0000, 8'h00, 1'b0, W_NONE},    // zero-length read
      '{MODE_WR_REQ,  24'hFFFFFE, 16'h0003, 8'h00, 1'b1, W_OPEN},    // write across wrap
      '{MODE_WR_REQ,  24'hFFFFFF, 16'hFFFF, 8'hFF, 1'b1, W_REJECT},  // request mid write
      '{MODE_WR_DATA, 24'h000000, 16'h0000, 8'hFF, 1'b0, W_NONE},
      '{MODE_WR_DATA, 24'h000000, 16'h0000, 8'h00, 1'b0, W_NONE},    // page end at wrap
      '{MODE_WR_REQ,  24'h000000, 16'h0001, 8'h00, 1'b1, W_REJECT},  // request mid poll
      '{MODE_REPLY,   24'h000000, 16'h0000, 8'hFF, 1'b0, W_NONE},    // still busy
      '{MODE_REPLY,   24'h000000, 16'h0000, 8'hFE, 1'b0, W_NONE},    // resume write
      '{MODE_WR_DATA, 24'h000000, 16'h0000, 8'hA5, 1'b0, W_NONE},    // full page frame
      '{MODE_REPLY,   24'h000000, 16'h0000, 8'h00, 1'b1, W_POLLED},
      '{MODE_SE,      24'h123456, 16'h0000, 8'h00, 1'b0, W_NONE},
      '{MODE_REPLY,   24'h000000, 16'h0000, 8'h01, 1'b0, W_NONE},
      '{MODE_REPLY,   24'h000000, 16'h0000, 8'h00, 1'b1, W_POLLED},
      '{MODE_BE,      24'h000000, 16'h0000, 8'h00, 1'b0, W_NONE},
      '{MODE_REPLY,   24'h000000, 16'h0000, 8'h02, 1'b1, W_POLLED},
      '{MODE_RD_REQ,  24'h800000, 16'h0002, 8'h00, 1'b0, W_NONE},
      '{MODE_REPLY,   24'h000000, 16'h0000, 8'h5A, 1'b0, W_NONE},
      '{MODE_WR_DATA, 24'h000000, 16'h0000, 8'h00, 1'b1, W_REJECT},  // data byte mid read
      '{MODE_REPLY,   24'h000000, 16'h0000, 8'hFF, 1'b0, W_NONE}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   spi_seq_req_if req_bus ();
   spi_seq_rsp_if rsp_bus ();

   spi_nor_flash_command_sequencer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // sequencer state as the host expects it
   spi_seq_phase_type    flash_phase  = PH_IDLE;
   logic [ADDR_BITS-1:0] next_addr    = '0;
   logic [LEN_BITS-1:0]  remain       = '0;
   logic                 frame_open   = 1'b0;
   logic                 resume_write = 1'b0;

   spi_seq_word_type step_words [$];
   spi_seq_word_type due_words [$];
   spi_seq_word_type got_word;
   int               errors        = 0;
   int               words_checked = 0;
   int               quiet_cycles  = 0;

   function automatic void put_word(input logic txv, input logic [BYTE_BITS-1:0] txb,
                                    input logic rel, input logic rep, input logic hv,
                                    input logic [BYTE_BITS-1:0] hd, input logic done,
                                    input logic st);
      spi_seq_word_type w;
      w = '{txv, txb, rel, rep, hv, hd, done, st, 1'b0};
      step_words.push_back(w);
   endfunction

   function automatic void send_byte(input logic [BYTE_BITS-1:0] b, input logic rel,
                                     input logic rep);
      put_word(1'b1, b, rel, rep, 1'b0, '0, 1'b0, 1'b0);
   endfunction

   // three address bytes, high first; release and done only on the low byte
   function automatic void send_addr(input logic [ADDR_BITS-1:0] a, input logic rel,
                                     input logic done);
      send_byte(a[23:16], 1'b0, 1'b0);
      send_byte(a[15:8], 1'b0, 1'b0);
      put_word(1'b1, a[7:0], rel, 1'b0, 1'b0, '0, done, 1'b0);
   endfunction

   function automatic void start_poll(input logic resume);
      send_byte(CMD_RDSR, 1'b0, 1'b0);
      send_byte(DUMMY, 1'b0, 1'b1);
      flash_phase  = PH_POLL;
      resume_write = resume;
   endfunction

   // flash words caused by one request word, left in step_words
   function automatic void predict_frames(input logic [MODE_BITS-1:0] m,
                                          input logic [ADDR_BITS-1:0] a,
                                          input logic [LEN_BITS-1:0] len,
                                          input logic [BYTE_BITS-1:0] d);
      spi_seq_word_type w;
      logic             page_end;
      step_words.delete();
      if (flash_phase == PH_IDLE && m == MODE_WR_REQ) begin
         next_addr    = a;
         remain       = len;
         frame_open   = 1'b0;
         resume_write = 1'b0;
         if (len == '0) begin
            put_word(1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b0);
         end else begin
            flash_phase = PH_WDATA;
            put_word(1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0);
         end
      end else if (flash_phase == PH_IDLE && m == MODE_RD_REQ) begin
         next_addr = a;
         remain    = len;
         send_byte(CMD_READ, 1'b0, 1'b0);
         if (len == '0) begin
            send_addr(a, 1'b1, 1'b1);
         end else begin
            send_addr(a, 1'b0, 1'b0);
            send_byte(DUMMY, 1'b0, 1'b1);
            flash_phase = PH_READ;
         end
      end else if (flash_phase == PH_IDLE && m == MODE_SE) begin
         send_byte(CMD_WREN, 1'b1, 1'b0);
         send_byte(CMD_SE, 1'b0, 1'b0);
         send_addr(a, 1'b1, 1'b0);
         start_poll(1'b0);
      end else if (flash_phase == PH_IDLE && m == MODE_BE) begin
         send_byte(CMD_WREN, 1'b1, 1'b0);
         send_byte(CMD_BE, 1'b1, 1'b0);
         start_poll(1'b0);
      end else if (flash_phase == PH_WDATA && m == MODE_WR_DATA) begin
         // page frame opens on its first data byte
         if (!frame_open) begin
            send_byte(CMD_WREN, 1'b1, 1'b0);
            send_byte(CMD_PROG, 1'b0, 1'b0);
            send_addr(next_addr, 1'b0, 1'b0);
            frame_open = 1'b1;
         end
         next_addr = next_addr + ADDR_BITS'(1);
         remain    = remain - LEN_BITS'(1);
         page_end  = (remain == '0) || (next_addr[PAGE_BITS-1:0] == '0);
         send_byte(d, page_end, 1'b0);
         if (page_end) begin
            frame_open = 1'b0;
            start_poll(1'b1);
         end
      end else if (flash_phase == PH_POLL && m == MODE_REPLY) begin
         if (d[WIP_POS]) begin
            send_byte(DUMMY, 1'b0, 1'b1);
         end else if (resume_write && remain != '0) begin
            put_word(1'b0, '0, 1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
            flash_phase = PH_WDATA;
         end else begin
            put_word(1'b0, '0, 1'b1, 1'b0, 1'b0, '0, 1'b1, 1'b0);
            flash_phase  = PH_IDLE;
            resume_write = 1'b0;
         end
      end else if (flash_phase == PH_READ && m == MODE_REPLY) begin
         remain = remain - LEN_BITS'(1);
         if (remain == '0) begin
            put_word(1'b0, '0, 1'b1, 1'b0, 1'b1, d, 1'b1, 1'b0);
            flash_phase = PH_IDLE;
         end else begin
            put_word(1'b1, DUMMY, 1'b0, 1'b1, 1'b1, d, 1'b0, 1'b0);
         end
      end else begin
         put_word(1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
      end
      w      = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
   endfunction

   function automatic string word_text(input spi_seq_word_type w);
      return $sformatf("tx %b/%h rel %b rep %b host %b/%h done %b st %b last %b",
                       w.tx_valid, w.tx_byte, w.cs_release, w.reply_wanted, w.host_valid,
                       w.host_data, w.done_res, w.status, w.last);
   endfunction

   // offer one request word after a random gap, then book its expected words
   task automatic offer_word(input logic [MODE_BITS-1:0] m, input logic [ADDR_BITS-1:0] a,
                             input logic [LEN_BITS-1:0] len, input logic [BYTE_BITS-1:0] d,
                             input logic typed, input spi_seq_word_type want);
      int r;
      int gap;
      r   = $urandom_range(0, 99);
      gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) :
            (r < 98) ? $urandom_range(4, 12) : $urandom_range(20, 40);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= m;
      req_bus.addr   <= a;
      req_bus.length <= len;
      req_bus.data   <= d;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_frames(m, a, len, d);
      if (typed) begin
         due_words.push_back(want);
      end else begin
         foreach (step_words[i]) due_words.push_back(step_words[i]);
      end
   endtask

   // request side: reset, directed rows, random traffic, drain and verdict
   initial begin : stimulus
      logic [MODE_BITS-1:0] m;
      logic [ADDR_BITS-1:0] a;
      logic [LEN_BITS-1:0]  len;
      logic [BYTE_BITS-1:0] d;
      int                   r;
      req_bus.valid  <= 1'b0;
      req_bus.mode   <= '0;
      req_bus.addr   <= '0;
      req_bus.length <= '0;
      req_bus.data   <= '0;
      reset          <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (PROBE_ROWS[i]) begin
         offer_word(PROBE_ROWS[i].mode, PROBE_ROWS[i].addr, PROBE_ROWS[i].length,
                    PROBE_ROWS[i].data, PROBE_ROWS[i].typed, PROBE_ROWS[i].want);
      end

      // random traffic steered by the expected phase
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         a   = ADDR_BITS'($urandom);
         len = LEN_BITS'($urandom);
         d   = BYTE_BITS'($urandom);
         m   = ALL_MODES[$urandom_range(0, 7)];
         r   = $urandom_range(0, 99);
         case (flash_phase)
            PH_IDLE: begin
               // address near a page end or at the top of the space now and then
               if ($urandom_range(0, 99) >= 60) begin
                  a[PAGE_BITS-1:0] = PAGE_BITS'(PAGE_BYTES - $urandom_range(1, 8));
                  if ($urandom_range(0, 3) == 0) a[ADDR_BITS-1:PAGE_BITS] = '1;
               end
               if (r < 32) begin
                  m   = MODE_WR_REQ;
                  r   = $urandom_range(0, 99);
                  len = (r < 80) ? LEN_BITS'($urandom_range(1, 6)) :
                        (r < 98) ? LEN_BITS'($urandom_range(7, 24)) :
                        LEN_BITS'($urandom_range(100, 160));
               end else if (r < 56) begin
                  m   = MODE_RD_REQ;
                  len = LEN_BITS'($urandom_range(1, 6));
               end else if (r < 66) begin
                  m = MODE_SE;
               end else if (r < 72) begin
                  m = MODE_BE;
               end else if (r < 80) begin
                  m   = ($urandom_range(0, 1) == 0) ? MODE_WR_REQ : MODE_RD_REQ;
                  len = '0;
               end
            end
            PH_WDATA: begin
               if (r < 92) m = MODE_WR_DATA;
            end
            default: begin
               // poll and read both take replies; a poll reply is often busy
               if (r < 90) begin
                  m = MODE_REPLY;
                  if (flash_phase == PH_POLL) d[WIP_POS] = ($urandom_range(0, 99) < 40);
               end
            end
         endcase
         offer_word(m, a, len, d, 1'b0, W_NONE);
      end
      req_bus.valid <= 1'b0;

      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result side: random stalls and one long hold-off to fill the block
   initial begin : result_stalls
      int  r;
      int  run;
      int  gap;
      bit  held_off;
      held_off = 1'b0;
      forever begin
         if (!held_off && words_checked >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
         repeat (run) @(posedge clock);
         r   = $urandom_range(0, 99);
         gap = (r < 70) ? $urandom_range(1, 2) : (r < 95) ? $urandom_range(3, 8) :
               $urandom_range(20, 40);
         rsp_bus.ready <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   end

   // compare each result word with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_word = '{rsp_bus.tx_valid, rsp_bus.tx_byte, rsp_bus.cs_release,
                      rsp_bus.reply_wanted, rsp_bus.host_valid, rsp_bus.host_data,
                      rsp_bus.done_res, rsp_bus.status, rsp_bus.last};
         words_checked++;
         if (due_words.size() == 0) begin
            errors++;
            if (errors <= SHOWN_ERRORS) begin
               $display("unexpected word: got %s", word_text(got_word));
            end
         end else if (got_word !== due_words[0]) begin
            errors++;
            if (errors <= SHOWN_ERRORS) begin
               $display("word %0d mismatch: expected %s", words_checked,
                        word_text(due_words[0]));
               $display("                  got      %s", word_text(got_word));
            end
            void'(due_words.pop_front());
         end else begin
            void'(due_words.pop_front());
         end
      end
   end

   // watchdog on cycles without any word moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
